[hdl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/binco_pkg.sv]
// constants and types shared by the binomial coefficient block
package binco_pkg;

    localparam int MAX_N   = 63;
    localparam int FIELD_W = 6;
    localparam int COEF_W  = 60;
    localparam int PROD_W  = COEF_W + FIELD_W;
    localparam int DIV_W   = 5;
    localparam int CNT_W   = $clog2(PROD_W);

    localparam logic [COEF_W-1:0] INT32_TOP = COEF_W'(64'd2147483647);

    typedef struct packed {
        logic              go;
        logic [PROD_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hdl/binomial_coefficient.sv]
// top level of the binomial coefficient block
//
// usage: drive count_n and choose_r and pulse start while busy is low; the
// transfer happens at that clock edge. busy stays high until the result has
// been shown. the result appears on coefficient and exceeds_int32 for exactly
// one cycle, marked by done; the receiver cannot stall it and must take it then.
// coefficient is the exact C(n, r), zero when r exceeds n, one when r is zero
// or equal to n. exceeds_int32 is set when the value is above 2^31 - 1.
// operation: the trivial cases give done in the cycle after the transfer. otherwise
// r is reduced to k = min(r, n - r) and k steps run, each one multiply by
// (n - k + i) followed by an exact division by i on a bit-serial divider that
// resolves one of 66 quotient bits a cycle.
// one item is in flight at a time; the next transfer can start the cycle
// after done. reset clears the sequencer and the divider; no item is kept.
`include "assert_macros.svh"

module binomial_coefficient
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [binco_pkg::FIELD_W-1:0]       count_n,
    input  logic [binco_pkg::FIELD_W-1:0]       choose_r,
    output logic                                busy,
    output logic                                done,
    output logic [binco_pkg::COEF_W-1:0]        coefficient,
    output logic                                exceeds_int32
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [binco_pkg::COEF_W-1:0]        acc_reg, acc_next;
    logic [binco_pkg::FIELD_W-1:0]       base_reg, base_next;
    logic [binco_pkg::DIV_W-1:0]         k_reg, k_next;
    logic [binco_pkg::DIV_W-1:0]         i_reg, i_next;
    logic [binco_pkg::FIELD_W-1:0]       n_minus_r;
    logic [binco_pkg::DIV_W-1:0]         k_min;
    logic [binco_pkg::FIELD_W-1:0]       factor;
    logic                                accept;
    binco_pkg::div_req_t                 div_req;
    binco_pkg::div_rsp_t                 div_rsp;

    assign accept    = start && !busy;
    assign n_minus_r = binco_pkg::FIELD_W'(count_n - choose_r);
    assign k_min     = (n_minus_r < choose_r) ? binco_pkg::DIV_W'(n_minus_r)
                                              : binco_pkg::DIV_W'(choose_r);
    assign factor    = binco_pkg::FIELD_W'(base_reg + {1'b0, i_reg});

    assign div_req.go       = (state_reg == ST_MUL);
    assign div_req.dividend = binco_pkg::PROD_W'(acc_reg) * binco_pkg::PROD_W'(factor);
    assign div_req.divisor  = i_reg;

    binco_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if ((32'(count_n) > binco_pkg::MAX_N) || (choose_r > count_n))
                    begin
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end
                    else if ((choose_r == '0) || (choose_r == count_n))
                    begin
                        acc_next   = binco_pkg::COEF_W'(1);
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        acc_next   = binco_pkg::COEF_W'(1);
                        k_next     = k_min;
                        base_next  = binco_pkg::FIELD_W'(count_n - {1'b0, k_min});
                        i_next     = binco_pkg::DIV_W'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    acc_next = div_rsp.quotient[binco_pkg::COEF_W-1:0];
                    if (i_reg == k_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        i_next     = binco_pkg::DIV_W'(i_reg + 1'b1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_OUT);
    assign coefficient   = acc_reg;
    assign exceeds_int32 = (acc_reg > binco_pkg::INT32_TOP);

    `ASSERT_NEXT(a_accept_busy, accept, busy)
    `ASSERT_NEXT(a_done_pulse, done, !done && !busy)
    `ASSERT_IMPLY(a_div_done_in_div, div_rsp.done, state_reg == ST_DIV)
    `ASSERT_IMPLY(a_step_bound, state_reg == ST_MUL, i_reg != '0 && i_reg <= k_reg)

endmodule

[hdl/binco_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module binco_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  binco_pkg::div_req_t req,
    output binco_pkg::div_rsp_t rsp
);

    logic [binco_pkg::PROD_W-1:0] quo_reg, quo_next;
    logic [binco_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [binco_pkg::DIV_W-1:0]  dsr_reg, dsr_next;
    logic [binco_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [binco_pkg::DIV_W:0]    trial;
    logic                         fits;

    assign trial = {rem_reg, quo_reg[binco_pkg::PROD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[binco_pkg::PROD_W-2:0], fits};
            rem_next = fits ? binco_pkg::DIV_W'(trial - {1'b0, dsr_reg})
                            : binco_pkg::DIV_W'(trial);
            cnt_next = binco_pkg::CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == binco_pkg::CNT_W'(binco_pkg::PROD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `ASSERT_NEXT(a_go_runs, req.go, run_reg)
    `ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `ASSERT_IMPLY(a_done_after_run, done_reg, !run_reg && cnt_reg == '0 || !run_reg)

endmodule

[tb/sv/binomial_coefficient_checker.sv]
// checker for the binomial coefficient block: predicts each result and compares it
module binomial_coefficient_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [binco_pkg::FIELD_W-1:0] count_n,
    input  logic [binco_pkg::FIELD_W-1:0] choose_r,
    input  logic                          done,
    input  logic [binco_pkg::COEF_W-1:0]  coefficient,
    input  logic                          exceeds_int32,
    output int                            pending,
    output int                            fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [binco_pkg::FIELD_W-1:0] n;
        logic [binco_pkg::FIELD_W-1:0] r;
        logic [binco_pkg::COEF_W-1:0]  coef;
        logic                          wide;
    } coef_entry_t;

    coef_entry_t coef_q[$];

    function automatic logic [binco_pkg::COEF_W-1:0] exact_binomial(input int n,
                                                                     input int r);
        bit [127:0] acc;
        int         k;
        int         i;
        if (r > n || n > binco_pkg::MAX_N)
            return '0;
        k = (n - r < r) ? n - r : r;
        acc = 1;
        for (i = 1; i <= k; i++)
            acc = acc * (n - k + i) / i;
        return acc[binco_pkg::COEF_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        coef_entry_t want;
        coef_entry_t got;
        if (rst_n)
        begin
            if (done)
            begin
                if (coef_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", coefficient));
                else
                begin
                    want = coef_q.pop_front();
                    if (coefficient !== want.coef)
                        report_mismatch($sformatf("C(%0d,%0d): coefficient %0d, want %0d",
                                                  want.n, want.r, coefficient, want.coef));
                    if (exceeds_int32 !== want.wide)
                        report_mismatch($sformatf("C(%0d,%0d): exceeds_int32 %b, want %b",
                                                  want.n, want.r, exceeds_int32, want.wide));
                end
            end
            if (start && !busy)
            begin
                got.n = count_n;
                got.r = choose_r;
                got.coef = exact_binomial(int'(count_n), int'(choose_r));
                got.wide = (got.coef > binco_pkg::INT32_TOP);
                coef_q.push_back(got);
            end
        end
        pending = coef_q.size();
    end

endmodule

[tb/sv/binomial_coefficient_tb.sv]
// top of the binomial coefficient testbench: clock, reset, stimulus and verdict
module binomial_coefficient_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASE_ITEMS = 67;
    localparam int DRAIN_CYCLES = 2200;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic [binco_pkg::FIELD_W-1:0] count_n;
    logic [binco_pkg::FIELD_W-1:0] choose_r;
    logic                          busy;
    logic                          done;
    logic [binco_pkg::COEF_W-1:0]  coefficient;
    logic                          exceeds_int32;

    int pending;
    int fail_count;
    int idle_pct = 0;
    int cycle_count = 0;

    int corner_n[$] = '{0, 0, 1, 1, 1, 63, 63, 63, 63, 63, 63, 62, 5, 2, 10, 10, 32, 33,
                        34, 33, 40, 21, 63};
    int corner_r[$] = '{0, 63, 0, 1, 63, 0, 63, 1, 62, 31, 32, 63, 7, 1, 3, 7, 16, 16,
                        17, 17, 0, 42, 42};
    int phase_pct[4] = '{0, 86, 28, 0};

    binomial_coefficient DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .count_n       (count_n),
        .choose_r      (choose_r),
        .busy          (busy),
        .done          (done),
        .coefficient   (coefficient),
        .exceeds_int32 (exceeds_int32)
    );

    binomial_coefficient_checker checker_inst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .count_n       (count_n),
        .choose_r      (choose_r),
        .done          (done),
        .coefficient   (coefficient),
        .exceeds_int32 (exceeds_int32),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("binomial_coefficient test failed");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_pair(input int n, input int r);
        bit accepted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            count_n <= binco_pkg::FIELD_W'($urandom);
            choose_r <= binco_pkg::FIELD_W'($urandom);
            @(negedge clk);
        end
        start <= 1'b1;
        count_n <= binco_pkg::FIELD_W'(n);
        choose_r <= binco_pkg::FIELD_W'(r);
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = !busy;
        end
        @(negedge clk);
    endtask

    // half short runs of the step loop, the rest random, full-size or out-of-range choices
    task automatic random_pair(output int n, output int r);
        int mode;
        int k;
        mode = $urandom_range(0, 9);
        n = $urandom_range(0, 63);
        if (mode < 5)
        begin
            k = $urandom_range(0, 4);
            if (k > n)
                k = n;
            r = $urandom_range(0, 1) ? k : n - k;
        end
        else if (mode < 8)
            r = $urandom_range(0, 63);
        else if (mode == 8)
        begin
            n = $urandom_range(0, 62);
            r = $urandom_range(n + 1, 63);
        end
        else
        begin
            n = $urandom_range(56, 63);
            r = $urandom_range(n / 2 - 2, n / 2 + 2);
        end
    endtask

    initial
    begin
        int n;
        int r;
        rst_n = 1'b0;
        start = 1'b0;
        count_n = '0;
        choose_r = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_n[i])
            send_pair(corner_n[i], corner_r[i]);

        foreach (phase_pct[p])
        begin
            idle_pct = phase_pct[p];
            repeat (PHASE_ITEMS)
            begin
                random_pair(n, r);
                send_pair(n, r);
            end
            // hold off until everything outstanding has come back
            start <= 1'b0;
            while (pending != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("binomial_coefficient test passed");
        else
            $display("binomial_coefficient test failed");
        $finish;
    end

endmodule
